>>> rtl/bis_pkg.sv
// ----------------------------------------------------------------------------
// bis_pkg
// Shared types, constants and the divider step for the bilinear image scaler.
// ----------------------------------------------------------------------------
`default_nettype none

package bis_pkg;

  // Build-time sizes
  localparam int MAX_SRC_WIDTH  = 256;
  localparam int MAX_SRC_HEIGHT = 256;
  localparam int MAX_DST_DIM    = 4096;
  localparam int FRAC_BITS      = 8;

  // Fixed field widths
  localparam int COORD_W   = 12;
  localparam int CHAN_W    = 8;
  localparam int PIX_W     = 3 * CHAN_W;
  localparam int SRC_CFG_W = 9;
  localparam int DST_CFG_W = 13;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 13;

  // Register indices
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTERP_MODE = 3'd4;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_REQUEST = 1'b1;
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;
  localparam logic MODE_HORIZ   = 1'b0;

  // Derived widths
  localparam int XW       = $clog2(MAX_SRC_WIDTH);
  localparam int YW       = $clog2(MAX_SRC_HEIGHT);
  localparam int SZX      = $clog2(MAX_SRC_WIDTH + 1);
  localparam int SZY      = $clog2(MAX_SRC_HEIGHT + 1);
  localparam int SZ_MAX_W = (SZX > SZY) ? SZX : SZY;
  localparam int DDW      = $clog2(MAX_DST_DIM + 1);
  localparam int RAM_DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int ADDR_W    = $clog2(RAM_DEPTH);

  localparam int RST_SRC_W = (MAX_SRC_WIDTH < 256) ? MAX_SRC_WIDTH : 256;
  localparam int RST_SRC_H = (MAX_SRC_HEIGHT < 256) ? MAX_SRC_HEIGHT : 256;
  localparam int RST_DST   = (MAX_DST_DIM < 256) ? MAX_DST_DIM : 256;

  // Divider: quotient < max source size * 2^FRAC
  localparam int MAXS     = (MAX_SRC_WIDTH > MAX_SRC_HEIGHT) ? MAX_SRC_WIDTH : MAX_SRC_HEIGHT;
  localparam int QB       = $clog2(MAXS) + FRAC_BITS;
  localparam int DIV_STEP = 6;
  localparam int DIV_ITER = (QB + DIV_STEP - 1) / DIV_STEP;
  localparam int QBP      = DIV_ITER * DIV_STEP;
  localparam int ITER_W   = (DIV_ITER > 1) ? $clog2(DIV_ITER) : 1;
  localparam int NUM_W    = COORD_W + SZ_MAX_W + FRAC_BITS;

  // Blend arithmetic
  localparam int WGT_W = 2 * FRAC_BITS + 1;
  localparam int ACC_W = 2 * FRAC_BITS + CHAN_W;
  localparam logic [FRAC_BITS:0] FRAC_ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;

  localparam logic [1:0] TAP_FIRST = 2'd0;
  localparam logic [1:0] TAP_LAST  = 2'd3;

  typedef struct packed {
    logic               command;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic [CHAN_W-1:0]  red_in;
    logic [CHAN_W-1:0]  green_in;
    logic [CHAN_W-1:0]  blue_in;
  } in_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
    logic              status;
  } out_item_t;

  typedef struct packed {
    logic [SZX-1:0] src_w;
    logic [SZY-1:0] src_h;
    logic           mode;
  } cfg_t;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_INTERP,
    OP_ERROR
  } op_kind_t;

  typedef struct packed {
    op_kind_t             kind;
    logic [XW-1:0]        x;
    logic [YW-1:0]        y;
    logic [FRAC_BITS-1:0] fx;
    logic [FRAC_BITS-1:0] fy;
    logic [PIX_W-1:0]     pix;
  } op_t;

  typedef enum logic {
    BK_IDLE,
    BK_READ
  } back_state_t;

  typedef struct packed {
    logic [DDW-1:0] rem;
    logic [QBP-1:0] num;
  } div_t;

  // DIV_STEP restoring-division steps
  function automatic div_t div_steps(div_t s, logic [DDW-1:0] d);
    div_t       r;
    logic [DDW:0] t;
    r = s;
    for (int i = 0; i < DIV_STEP; i++) begin
      t     = {r.rem, r.num[QBP-1]};
      r.num = {r.num[QBP-2:0], 1'b0};
      if (t >= {1'b0, d}) begin
        t        = t - {1'b0, d};
        r.num[0] = 1'b1;
      end
      r.rem = t[DDW-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/bis_ram.sv
// ----------------------------------------------------------------------------
// bis_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bis_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> rtl/bis_queue.sv
// ----------------------------------------------------------------------------
// bis_queue
// Two-entry queue of classified operations between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module bis_queue (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  bis_pkg::op_t push_op,
  output logic         pop_valid,
  input  logic         pop_ready,
  output bis_pkg::op_t pop_op
);
  import bis_pkg::*;

  localparam int DEPTH = 2;

  op_t        slot_r [DEPTH];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign push_ready = (cnt_r != 2'(DEPTH));
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_op     = slot_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wp_nxt  = do_push ? ~wp_r : wp_r;
    rp_nxt  = do_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= push_op;
    end
  end

endmodule

`default_nettype wire

>>> rtl/bis_front.sv
// ----------------------------------------------------------------------------
// bis_front
// Configuration registers, input acceptance, range checks and coordinate
// mapping (multiply then iterative divide) into classified operations.
// ----------------------------------------------------------------------------
`default_nettype none

module bis_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  bis_pkg::in_item_t                  in_data,
  input  logic                               cfg_we,
  input  logic [bis_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bis_pkg::CFG_DAT_W-1:0]      cfg_wdata,
  output bis_pkg::cfg_t                      cfg,
  output logic                               op_valid,
  input  logic                               op_ready,
  output bis_pkg::op_t                       op
);
  import bis_pkg::*;

  logic [SZX-1:0] src_w_r, src_w_nxt;
  logic [SZY-1:0] src_h_r, src_h_nxt;
  logic [DDW-1:0] dst_w_r, dst_w_nxt, dst_h_r, dst_h_nxt;
  logic           mode_r, mode_nxt;

  logic              busy_r, busy_nxt;
  logic [ITER_W-1:0] it_r, it_nxt;
  div_t              dx_r, dx_nxt, dy_r, dy_nxt;
  div_t              dx_step, dy_step;
  op_t               op_r, op_nxt;
  logic              op_valid_r, op_valid_nxt;

  logic             in_fire, last_iter;
  logic [NUM_W-1:0] nx, ny;

  function automatic logic [SZX-1:0] clamp_sx(logic [SRC_CFG_W-1:0] v);
    if (v == '0) return SZX'(1);
    if (int'(v) > MAX_SRC_WIDTH) return SZX'(MAX_SRC_WIDTH);
    return SZX'(v);
  endfunction

  function automatic logic [SZY-1:0] clamp_sy(logic [SRC_CFG_W-1:0] v);
    if (v == '0) return SZY'(1);
    if (int'(v) > MAX_SRC_HEIGHT) return SZY'(MAX_SRC_HEIGHT);
    return SZY'(v);
  endfunction

  function automatic logic [DDW-1:0] clamp_d(logic [DST_CFG_W-1:0] v);
    if (v == '0) return DDW'(1);
    if (int'(v) > MAX_DST_DIM) return DDW'(MAX_DST_DIM);
    return DDW'(v);
  endfunction

  assign in_ready  = !busy_r && (!op_valid_r || op_ready);
  assign in_fire   = in_valid && in_ready;
  assign last_iter = (it_r == ITER_W'(DIV_ITER - 1));
  assign dx_step   = div_steps(dx_r, dst_w_r);
  assign dy_step   = div_steps(dy_r, dst_h_r);

  // Numerators: coord * src << FRAC
  assign nx = NUM_W'(NUM_W'(in_data.column) * NUM_W'(src_w_r)) << FRAC_BITS;
  assign ny = NUM_W'(NUM_W'(in_data.row) * NUM_W'(src_h_r)) << FRAC_BITS;

  // Configuration
  always_comb begin
    src_w_nxt = src_w_r;
    src_h_nxt = src_h_r;
    dst_w_nxt = dst_w_r;
    dst_h_nxt = dst_h_r;
    mode_nxt  = mode_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_SRC_WIDTH:   src_w_nxt = clamp_sx(cfg_wdata[SRC_CFG_W-1:0]);
        REG_SRC_HEIGHT:  src_h_nxt = clamp_sy(cfg_wdata[SRC_CFG_W-1:0]);
        REG_DST_WIDTH:   dst_w_nxt = clamp_d(cfg_wdata[DST_CFG_W-1:0]);
        REG_DST_HEIGHT:  dst_h_nxt = clamp_d(cfg_wdata[DST_CFG_W-1:0]);
        REG_INTERP_MODE: mode_nxt  = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Classification and divider sequencing
  always_comb begin
    busy_nxt     = busy_r;
    it_nxt       = it_r;
    dx_nxt       = dx_r;
    dy_nxt       = dy_r;
    op_nxt       = op_r;
    op_valid_nxt = op_valid_r && !op_ready;

    if (in_fire) begin
      op_nxt.x   = in_data.column[XW-1:0];
      op_nxt.y   = in_data.row[YW-1:0];
      op_nxt.fx  = '0;
      op_nxt.fy  = '0;
      op_nxt.pix = {in_data.red_in, in_data.green_in, in_data.blue_in};
      if (in_data.command == CMD_LOAD) begin
        op_nxt.kind = OP_LOAD;
        if (32'(in_data.column) < 32'(src_w_r) && 32'(in_data.row) < 32'(src_h_r)) begin
          op_valid_nxt = 1'b1;
        end
      end else if (32'(in_data.column) >= 32'(dst_w_r) ||
                   32'(in_data.row) >= 32'(dst_h_r)) begin
        op_nxt.kind  = OP_ERROR;
        op_valid_nxt = 1'b1;
      end else begin
        busy_nxt   = 1'b1;
        it_nxt     = '0;
        dx_nxt.rem = DDW'(nx >> QBP);
        dx_nxt.num = QBP'(nx);
        dy_nxt.rem = DDW'(ny >> QBP);
        dy_nxt.num = QBP'(ny);
      end
    end

    if (busy_r) begin
      dx_nxt = dx_step;
      dy_nxt = dy_step;
      it_nxt = it_r + ITER_W'(1);
      if (last_iter) begin
        busy_nxt     = 1'b0;
        op_nxt.kind  = OP_INTERP;
        op_nxt.x     = dx_step.num[FRAC_BITS +: XW];
        op_nxt.fx    = dx_step.num[FRAC_BITS-1:0];
        op_nxt.y     = dy_step.num[FRAC_BITS +: YW];
        op_nxt.fy    = dy_step.num[FRAC_BITS-1:0];
        op_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r    <= SZX'(RST_SRC_W);
      src_h_r    <= SZY'(RST_SRC_H);
      dst_w_r    <= DDW'(RST_DST);
      dst_h_r    <= DDW'(RST_DST);
      mode_r     <= 1'b1;
      busy_r     <= 1'b0;
      it_r       <= '0;
      op_valid_r <= 1'b0;
    end else begin
      src_w_r    <= src_w_nxt;
      src_h_r    <= src_h_nxt;
      dst_w_r    <= dst_w_nxt;
      dst_h_r    <= dst_h_nxt;
      mode_r     <= mode_nxt;
      busy_r     <= busy_nxt;
      it_r       <= it_nxt;
      op_valid_r <= op_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dx_r <= dx_nxt;
    dy_r <= dy_nxt;
    op_r <= op_nxt;
  end

  assign op_valid  = op_valid_r;
  assign op        = op_r;
  assign cfg.src_w = src_w_r;
  assign cfg.src_h = src_h_r;
  assign cfg.mode  = mode_r;

endmodule

`default_nettype wire

>>> rtl/bis_back.sv
// ----------------------------------------------------------------------------
// bis_back
// Frame store, four-tap read sequencer, weighted accumulation and result
// buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module bis_back (
  input  logic               clk,
  input  logic               rst_n,
  input  bis_pkg::cfg_t      cfg,
  input  logic               q_valid,
  output logic               q_pop,
  input  bis_pkg::op_t       q_op,
  output logic               out_valid,
  input  logic               out_ready,
  output bis_pkg::out_item_t out_data
);
  import bis_pkg::*;

  localparam int RES_DEPTH = 2;

  typedef struct packed {
    logic [XW-1:0]        x0;
    logic [XW-1:0]        x1;
    logic [YW-1:0]        y0;
    logic [YW-1:0]        y1;
    logic [FRAC_BITS-1:0] fx;
    logic [FRAC_BITS-1:0] fy;
  } cur_t;

  back_state_t state_r, state_nxt;
  logic [1:0]  tap_r, tap_nxt;
  cur_t        cur_r, cur_nxt;

  logic take, ram_we, ram_re, err_push, fin_push, can_res;

  logic [ADDR_W-1:0] raddr, waddr;
  logic [XW-1:0]     rx;
  logic [YW-1:0]     ry;
  logic [PIX_W-1:0]  rdata;

  logic [FRAC_BITS:0] wx, wy;
  logic [WGT_W-1:0]   weight_r;
  logic               tapv_r;
  logic [1:0]         tapd_r;
  logic [ACC_W-1:0]   acc_r [3];
  logic [ACC_W-1:0]   acc_nxt [3];

  logic [1:0] resv_r, resv_nxt;
  out_item_t  rb_r [RES_DEPTH];
  logic       rwp_r, rrp_r;
  logic [1:0] rcnt_r;
  logic       res_push, res_pop;
  out_item_t  res_item;

  assign can_res = (resv_r != 2'(RES_DEPTH));

  // Decisions for the current cycle
  always_comb begin
    q_pop    = 1'b0;
    take     = 1'b0;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    err_push = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          case (q_op.kind)
            OP_LOAD: begin
              q_pop  = 1'b1;
              ram_we = 1'b1;
            end
            OP_INTERP: begin
              q_pop = can_res;
              take  = can_res;
            end
            OP_ERROR: begin
              q_pop    = can_res && !tapv_r;
              err_push = can_res && !tapv_r;
            end
            default: q_pop = 1'b1;
          endcase
        end
      end
      BK_READ: begin
        ram_re = 1'b1;
        if (tap_r == TAP_LAST && q_valid && q_op.kind == OP_INTERP && can_res) begin
          q_pop = 1'b1;
          take  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    tap_nxt   = tap_r;
    case (state_r)
      BK_IDLE: begin
        if (take) begin
          state_nxt = BK_READ;
          tap_nxt   = TAP_FIRST;
        end
      end
      BK_READ: begin
        tap_nxt = tap_r + 2'd1;
        if (tap_r == TAP_LAST && !take) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Neighbour columns and rows, wrapped; in horizontal mode the lower row is the upper row
  always_comb begin
    cur_nxt = cur_r;
    if (take) begin
      cur_nxt.x0 = q_op.x;
      cur_nxt.y0 = q_op.y;
      cur_nxt.fx = q_op.fx;
      cur_nxt.fy = q_op.fy;
      cur_nxt.x1 = (32'(q_op.x) + 1 >= 32'(cfg.src_w)) ? '0 : q_op.x + XW'(1);
      if (cfg.mode == MODE_HORIZ) begin
        cur_nxt.y1 = q_op.y;
      end else begin
        cur_nxt.y1 = (32'(q_op.y) + 1 >= 32'(cfg.src_h)) ? '0 : q_op.y + YW'(1);
      end
    end
  end

  assign rx    = tap_r[0] ? cur_r.x1 : cur_r.x0;
  assign ry    = tap_r[1] ? cur_r.y1 : cur_r.y0;
  assign raddr = ADDR_W'(ADDR_W'(ry) * ADDR_W'(MAX_SRC_WIDTH)) + ADDR_W'(rx);
  assign waddr = ADDR_W'(ADDR_W'(q_op.y) * ADDR_W'(MAX_SRC_WIDTH)) + ADDR_W'(q_op.x);
  assign wx    = tap_r[0] ? {1'b0, cur_r.fx} : FRAC_ONE - {1'b0, cur_r.fx};
  assign wy    = tap_r[1] ? {1'b0, cur_r.fy} : FRAC_ONE - {1'b0, cur_r.fy};

  bis_ram #(
    .WIDTH(PIX_W),
    .DEPTH(RAM_DEPTH)
  ) u_frame (
    .clk  (clk),
    .we   (ram_we),
    .waddr(waddr),
    .wdata(q_op.pix),
    .re   (ram_re),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Accumulate one tap per cycle
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      acc_nxt[c] = ((tapd_r == TAP_FIRST) ? '0 : acc_r[c]) +
                   ACC_W'(weight_r) * ACC_W'(rdata[(2 - c) * CHAN_W +: CHAN_W]);
    end
  end

  assign fin_push = tapv_r && (tapd_r == TAP_LAST);

  always_ff @(posedge clk) begin
    weight_r <= WGT_W'(wx) * WGT_W'(wy);
    tapd_r   <= tap_r;
    cur_r    <= cur_nxt;
    if (tapv_r) begin
      for (int c = 0; c < 3; c++) begin
        acc_r[c] <= acc_nxt[c];
      end
    end
  end

  // Result buffer
  always_comb begin
    if (fin_push) begin
      res_item.red_out   = acc_nxt[0][2*FRAC_BITS +: CHAN_W];
      res_item.green_out = acc_nxt[1][2*FRAC_BITS +: CHAN_W];
      res_item.blue_out  = acc_nxt[2][2*FRAC_BITS +: CHAN_W];
      res_item.status    = STATUS_OK;
    end else begin
      res_item.red_out   = '0;
      res_item.green_out = '0;
      res_item.blue_out  = '0;
      res_item.status    = STATUS_RANGE;
    end
  end

  assign res_push  = fin_push || err_push;
  assign out_valid = (rcnt_r != 2'd0);
  assign res_pop   = out_valid && out_ready;
  assign out_data  = rb_r[rrp_r];
  assign resv_nxt  = resv_r + 2'(take || err_push) - 2'(res_pop);

  always_ff @(posedge clk) begin
    if (res_push) begin
      rb_r[rwp_r] <= res_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      tap_r   <= TAP_FIRST;
      tapv_r  <= 1'b0;
      resv_r  <= 2'd0;
      rwp_r   <= 1'b0;
      rrp_r   <= 1'b0;
      rcnt_r  <= 2'd0;
    end else begin
      state_r <= state_nxt;
      tap_r   <= tap_nxt;
      tapv_r  <= ram_re;
      resv_r  <= resv_nxt;
      rwp_r   <= res_push ? ~rwp_r : rwp_r;
      rrp_r   <= res_pop ? ~rrp_r : rrp_r;
      rcnt_r  <= rcnt_r + 2'(res_push) - 2'(res_pop);
    end
  end

endmodule

`default_nettype wire

>>> rtl/bilinear_image_scaler_unit.sv
// ----------------------------------------------------------------------------
// bilinear_image_scaler_unit
// RGB source frame store with bilinear (or horizontal-only) resampling of
// requested destination pixels.
// ----------------------------------------------------------------------------
//
//  channel   ports                          transfer when
//  -------   -----------------------------  --------------------------------
//  input     in_valid  in_ready  in_data    in_valid && in_ready
//  result    out_valid out_ready out_data   out_valid && out_ready
//  config    cfg_we cfg_index cfg_wdata     cfg_we (no wait, no read-back)
//
//  A request is accepted and forms x*src, y*src, then runs three divider
//  iterations of 6 quotient bits, and the front takes no new item until
//  they are done; the back end reads the four neighbours on the single
//  frame-store read port. Loads and out-of-range requests skip the divider.
//  Reset is synchronous on rst_n; the frame store has no clearing pass and
//  holds nothing defined until loaded. A two-entry op queue and a two-entry
//  result buffer let either side stall.
//
`default_nettype none

module bilinear_image_scaler_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  bis_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output bis_pkg::out_item_t                 out_data,
  input  logic                               cfg_we,
  input  logic [bis_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bis_pkg::CFG_DAT_W-1:0]      cfg_wdata
);
  import bis_pkg::*;

  cfg_t cfg;
  op_t  f_op, q_op;
  logic f_valid, f_ready, q_valid, q_pop;

  // Front: config, classify, map coordinates
  bis_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .cfg      (cfg),
    .op_valid (f_valid),
    .op_ready (f_ready),
    .op       (f_op)
  );

  // Decoupling queue
  bis_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(f_valid),
    .push_ready(f_ready),
    .push_op   (f_op),
    .pop_valid (q_valid),
    .pop_ready (q_pop),
    .pop_op    (q_op)
  );

  // Back: frame store, blend, result buffer
  bis_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_op     (q_op),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

>>> tb/sv/bilinear_image_scaler_unit_test.sv
// ----------------------------------------------------------------------------
// bilinear_image_scaler_unit_test
// Self-checking bench for the bilinear image scaler: source pixels are loaded
// and destination pixels requested under several size and mode settings, and
// every result is checked against an in-bench model of the frame store.
// ----------------------------------------------------------------------------
`default_nettype none

module bilinear_image_scaler_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bis_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 16;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_wdata;

  bilinear_image_scaler_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Mirror of the block's frame store and registers
  logic [PIX_W-1:0] pixel_store [RAM_DEPTH];
  bit               pixel_loaded [RAM_DEPTH];
  int unsigned      src_w, src_h, dst_w, dst_h;
  logic             blend_mode;

  out_item_t pending_pixels[$];   // expected results, oldest first

  int  error_count;
  int  requests_sent, loads_sent, results_seen, range_results;
  bit  sender_burst;              // no gaps between transfers while set

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic int unsigned size_limit(int unsigned v, int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // Destination coordinate to source integer part and 8-bit fraction
  function automatic void map_to_source(int unsigned d, int unsigned s, int unsigned dd,
                                        output int unsigned ipart,
                                        output int unsigned frac);
    longint unsigned pos;
    pos   = ((longint'(d) * s) << FRAC_BITS) / dd;
    ipart = int'(pos >> FRAC_BITS);
    frac  = int'(pos & ((1 << FRAC_BITS) - 1));
  endfunction

  // Addresses of the four neighbours (upper-left, upper-right, lower-left,
  // lower-right) and the two fractions of an in-range request.
  function automatic void neighbours(int unsigned col, int unsigned row,
                                     output int unsigned addr[4],
                                     output int unsigned fx, output int unsigned fy);
    int unsigned x0, y0, x1, y1;
    map_to_source(col, src_w, dst_w, x0, fx);
    map_to_source(row, src_h, dst_h, y0, fy);
    x1 = (x0 + 1 >= src_w) ? 0 : x0 + 1;
    if (blend_mode != MODE_HORIZ) y1 = (y0 + 1 >= src_h) ? 0 : y0 + 1;
    else y1 = y0;
    addr[0] = y0 * MAX_SRC_WIDTH + x0;
    addr[1] = y0 * MAX_SRC_WIDTH + x1;
    addr[2] = y1 * MAX_SRC_WIDTH + x0;
    addr[3] = y1 * MAX_SRC_WIDTH + x1;
  endfunction

  function automatic out_item_t resample(int unsigned col, int unsigned row);
    out_item_t       r;
    int unsigned     addr[4];
    int unsigned     fx, fy, sh;
    longint unsigned wt[4];
    longint unsigned acc;
    logic [7:0]      chan[3];
    r = '0;
    if (col >= dst_w || row >= dst_h) begin
      r.status = STATUS_RANGE;
      return r;
    end
    neighbours(col, row, addr, fx, fy);
    wt[0] = (256 - fx) * (256 - fy);
    wt[1] = fx * (256 - fy);
    wt[2] = (256 - fx) * fy;
    wt[3] = fx * fy;
    for (int c = 0; c < 3; c++) begin
      sh  = 16 - 8 * c;
      acc = 0;
      for (int k = 0; k < 4; k++)
        acc += wt[k] * ((pixel_store[addr[k]] >> sh) & 8'hFF);
      chan[c] = 8'((acc >> (2 * FRAC_BITS)) & 8'hFF);
    end
    r.red_out   = chan[0];
    r.green_out = chan[1];
    r.blue_out  = chan[2];
    r.status    = STATUS_OK;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Configuration writes, only while the block is idle
  // --------------------------------------------------------------------------
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DAT_W'(value);
    case (idx)
      REG_SRC_WIDTH:   src_w = size_limit(value & 9'h1FF, MAX_SRC_WIDTH);
      REG_SRC_HEIGHT:  src_h = size_limit(value & 9'h1FF, MAX_SRC_HEIGHT);
      REG_DST_WIDTH:   dst_w = size_limit(value & 13'h1FFF, MAX_DST_DIM);
      REG_DST_HEIGHT:  dst_h = size_limit(value & 13'h1FFF, MAX_DST_DIM);
      REG_INTERP_MODE: blend_mode = value[0];
      default: ;       // unknown index: ignored by the block too
    endcase
    @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Drop in_valid after the last transfer of a run of items
  task automatic idle_input;
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Wait until every expected result has come, then let loads still in the
  // pipeline settle.
  task automatic drain;
    idle_input();
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_geometry(int unsigned sw, int unsigned sh, int unsigned dw,
                              int unsigned dh, logic mode);
    drain();
    write_reg(REG_SRC_WIDTH, sw);
    write_reg(REG_SRC_HEIGHT, sh);
    write_reg(REG_DST_WIDTH, dw);
    write_reg(REG_DST_HEIGHT, dh);
    write_reg(REG_INTERP_MODE, mode);
  endtask

  // --------------------------------------------------------------------------
  // Sender: one transfer on the input channel; in_valid stays high after the
  // accepting edge so that a following item can go out with no gap
  // --------------------------------------------------------------------------
  task automatic send_item(in_item_t item);
    int gap;
    gap = sender_burst ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    // accepted at this edge: update the model
    if (item.command == CMD_LOAD) begin
      loads_sent++;
      if (item.column < src_w && item.row < src_h) begin
        pixel_store[item.row * MAX_SRC_WIDTH + item.column] =
          {item.red_in, item.green_in, item.blue_in};
        pixel_loaded[item.row * MAX_SRC_WIDTH + item.column] = 1'b1;
      end
    end else begin
      requests_sent++;
      pending_pixels.push_back(resample(item.column, item.row));
    end
  endtask

  task automatic load_pixel(int unsigned col, int unsigned row, logic [PIX_W-1:0] rgb);
    in_item_t it;
    it = '{command: CMD_LOAD, column: COORD_W'(col), row: COORD_W'(row),
           red_in: rgb[23:16], green_in: rgb[15:8], blue_in: rgb[7:0]};
    send_item(it);
  endtask

  // A request; neighbours never loaded are loaded first so that no read of an
  // undefined entry is caused.
  task automatic request_pixel(int unsigned col, int unsigned row);
    in_item_t    it;
    int unsigned addr[4];
    int unsigned fx, fy;
    if (col < dst_w && row < dst_h) begin
      neighbours(col, row, addr, fx, fy);
      for (int k = 0; k < 4; k++)
        if (!pixel_loaded[addr[k]])
          load_pixel(addr[k] % MAX_SRC_WIDTH, addr[k] / MAX_SRC_WIDTH, PIX_W'($urandom));
    end
    it = '{command: CMD_REQUEST, column: COORD_W'(col), row: COORD_W'(row),
           red_in: 8'($urandom), green_in: 8'($urandom), blue_in: 8'($urandom)};
    send_item(it);
  endtask

  // Mostly well-formed requests, with loads and out-of-range items mixed in.
  // count is in input transfers, neighbour loads included.
  task automatic random_items(int count);
    int unsigned pick, col, row;
    int start, done;
    start = loads_sent + requests_sent;
    done  = 0;
    while (done < count) begin
      if (done % 40 == 0) sender_burst = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 74) begin
        request_pixel($urandom_range(0, dst_w - 1), $urandom_range(0, dst_h - 1));
      end else if (pick < 84) begin
        // out of the destination frame: any bit pattern beyond the size
        col = $urandom_range(0, 4095);
        row = $urandom_range(0, 4095);
        if (col >= dst_w || row >= dst_h) begin
          request_pixel(col, row);
        end
      end else if (pick < 95) begin
        load_pixel($urandom_range(0, src_w - 1), $urandom_range(0, src_h - 1),
                   PIX_W'($urandom));
      end else begin
        // ignored load
        col = $urandom_range(0, 4095);
        row = $urandom_range(0, 4095);
        if (col >= src_w || row >= src_h) load_pixel(col, row, PIX_W'($urandom));
      end
      done = loads_sent + requests_sent - start;
    end
    sender_burst = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_reset_defaults;
    // reset geometry: 256x256 to 256x256, full bilinear
    load_pixel(0, 0, 24'hFFFFFF);
    load_pixel(1, 0, 24'h000000);
    load_pixel(0, 1, 24'hFF00FF);
    load_pixel(1, 1, 24'h00FF00);
    load_pixel(255, 255, 24'h123456);
    load_pixel(0, 255, 24'hABCDEF);
    load_pixel(255, 0, 24'h80FF01);
    load_pixel(4095, 4095, 24'hFFFFFF);    // outside the source: ignored
    load_pixel(256, 0, 24'h5A5A5A);        // just outside: ignored
    request_pixel(0, 0);
    request_pixel(255, 255);               // wraps right and bottom
    request_pixel(255, 0);
    request_pixel(0, 255);
    request_pixel(256, 0);                 // outside the destination
    request_pixel(0, 256);
    request_pixel(4095, 4095);
  endtask

  task automatic test_small_bilinear;
    set_geometry(5, 3, 13, 7, 1'b1);
    request_pixel(12, 6);
    request_pixel(6, 3);
    random_items(120);
    // hold the sender until the block has answered everything
    idle_input();
    while (pending_pixels.size() != 0) @(posedge clk);
    random_items(120);
  endtask

  task automatic test_horizontal_only;
    set_geometry(5, 3, 13, 7, MODE_HORIZ);
    request_pixel(12, 6);
    random_items(120);
  endtask

  task automatic test_size_limits;
    // zero acts as one, oversize saturates, unknown index ignored
    drain();
    write_reg(REG_SRC_WIDTH, 0);
    write_reg(REG_SRC_HEIGHT, 300);
    write_reg(REG_DST_WIDTH, 8191);
    write_reg(REG_DST_HEIGHT, 0);
    write_reg(REG_INTERP_MODE, MODE_HORIZ);
    write_reg(3'd5, 13'h1FFF);
    write_reg(3'd7, 0);
    request_pixel(4095, 0);
    request_pixel(0, 1);
    random_items(120);
    set_geometry(256, 256, 1, 4096, 1'b1);
    request_pixel(0, 4095);
    random_items(80);
  endtask

  task automatic test_upscale_max;
    set_geometry(256, 256, 4096, 4096, 1'b1);
    request_pixel(4095, 4095);
    request_pixel(4095, 0);
    random_items(180);
  endtask

  task automatic test_downscale;
    set_geometry(200, 37, 3, 2, 1'b1);
    random_items(100);
    set_geometry(2, 2, 1, 1, MODE_HORIZ);
    random_items(40);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stall before each result
  // --------------------------------------------------------------------------
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 17);
      @(negedge clk);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: field by field against the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_pixels.size() == 0) begin
        $error("result transfer with nothing expected: %h", out_data);
        error_count++;
      end else begin
        want = pending_pixels.pop_front();
        if (want.status == STATUS_RANGE) range_results++;
        if (out_data.red_out !== want.red_out) begin
          $error("red_out expected %0d got %0d", want.red_out, out_data.red_out);
          error_count++;
        end
        if (out_data.green_out !== want.green_out) begin
          $error("green_out expected %0d got %0d", want.green_out, out_data.green_out);
          error_count++;
        end
        if (out_data.blue_out !== want.blue_out) begin
          $error("blue_out expected %0d got %0d", want.blue_out, out_data.blue_out);
          error_count++;
        end
        if (out_data.status !== want.status) begin
          $error("status expected %0d got %0d", want.status, out_data.status);
          error_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: cycles with no transfer on either channel
  // --------------------------------------------------------------------------
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("timeout: %0d results still outstanding", pending_pixels.size());
        $display("bilinear_image_scaler_unit_test: errors");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    rst_n     = 1'b0;
    error_count = 0;
    requests_sent = 0; loads_sent = 0; results_seen = 0; range_results = 0;
    sender_burst = 1'b0;
    src_w = 256; src_h = 256; dst_w = 256; dst_h = 256; blend_mode = 1'b1;
    foreach (pixel_store[i]) begin
      pixel_store[i]  = '0;
      pixel_loaded[i] = 1'b0;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_small_bilinear();
    test_horizontal_only();
    test_size_limits();
    test_upscale_max();
    test_downscale();

    drain();
    $display("covered %0d load and %0d request transfers, %0d results (%0d out of range)",
             loads_sent, requests_sent, results_seen, range_results);
    $display("geometries: reset, small, horizontal, size limits, 4096 upscale, downscale");
    if (error_count == 0)
      $display("bilinear_image_scaler_unit_test: clean");
    else
      $display("bilinear_image_scaler_unit_test: errors");
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
rtl/bis_pkg.sv
rtl/bis_ram.sv
rtl/bis_queue.sv
rtl/bis_front.sv
rtl/bis_back.sv
rtl/bilinear_image_scaler_unit.sv
tb/sv/bilinear_image_scaler_unit_test.sv
